/* src/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that must also hold while reset is applied.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/brs_pkg.sv */
// Package for the burst rate emission scheduler: widths, codes and state type.
// No dependencies.
`timescale 1ns / 1ps

package brs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RATE_W    = 16;
    localparam int ELAPSED_W = 20;
    localparam int TIME_W    = 24;
    localparam int PHASE_W   = 32;
    localparam int COUNT_W   = 16;
    localparam int OPCODE_W  = 2;
    localparam int MODE_W    = 2;
    localparam int PROD_W    = RATE_W + ELAPSED_W;
    localparam int QUOT_W    = PROD_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(QUOT_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = TIME_W;
    localparam int S_TDATA_W = ((ELAPSED_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COUNT_W + 2 + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CONT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERVAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BURST    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EMIT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_SETTLE,
        ST_FINISH
    } state_t;

endpackage

/* src/burst_rate_emission_scheduler.sv */
// Burst rate emission scheduler: top level with bit-serial multiply and divide.
// Depends on brs_pkg and assert_macros.svh.
//
// Usage:
// - Input stream s_*: one beat per item; opcode tick, start or stop on s_tuser,
//   elapsed time of a tick on s_tdata. One result beat on m_* follows every
//   input beat.
// - Config stream cfg_*: register index and data, always ready; write only
//   while no item is in flight.
// - Start and stop (and unknown opcodes) go from acceptance straight to the
//   finish state and its result.
// - A tick that emits in continuous mode runs the shift-add multiplier (one
//   rate bit per cycle), then settles; a tick in interval or burst mode that
//   spreads events also runs the restoring divider by on_time (one quotient bit
//   per cycle) before it settles; a tick that emits nothing goes from the
//   decide state straight to finish.
// - One item is in work at a time; the next beat is taken as soon as the
//   sequencer is back in idle, even while a result waits in the output register.
// - If the receiver stalls, the finished item holds in the sequencer until the
//   output register frees up.
// - Reset clears the config registers, phase time, carry and emitting flag, and
//   empties the output register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module burst_rate_emission_scheduler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [brs_pkg::S_TDATA_W-1:0]     s_tdata,   // elapsed_time, zero pad
    input  logic [brs_pkg::OPCODE_W-1:0]      s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [brs_pkg::M_TDATA_W-1:0]     m_tdata,   // emit_count, count_saturated,
                                                         // emitting_now, zero pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [brs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import brs_pkg::*;

    state_t                state_reg,   state_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [TIME_W-1:0]     on_reg;
    logic [TIME_W-1:0]     off_reg;

    logic [PHASE_W-1:0]    phase_reg,   phase_next;
    logic [FRAC_BITS-1:0]  carry_reg,   carry_next;
    logic                  flag_reg,    flag_next;

    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [RATE_W-1:0]     rsh_reg,     rsh_next;
    logic [PROD_W-1:0]     acc_reg,     acc_next;
    logic [QUOT_W-1:0]     dq_reg,      dq_next;
    logic [TIME_W-1:0]     rem_reg,     rem_next;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic                  spread_reg,  spread_next;
    logic [COUNT_W-1:0]    count_reg,   count_next;
    logic                  sat_reg,     sat_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_sat_reg,   out_sat_next;
    logic                  out_flag_reg,  out_flag_next;

    logic [OPCODE_W-1:0]   in_opcode;
    logic [ELAPSED_W-1:0]  in_elapsed;
    logic                  in_beat;
    logic                  start_beat;
    logic                  div_busy;
    logic [PHASE_W:0]      phase_sum;
    logic [PHASE_W-1:0]    on_ext;
    logic [PHASE_W-1:0]    off_ext;
    logic [PROD_W-1:0]     mul_step;
    logic [TIME_W:0]       trial;
    logic                  trial_ge;
    logic [TIME_W:0]       trial_diff;
    logic [QUOT_W:0]       total;
    logic                  total_sat;

    assign in_opcode  = s_tuser;
    assign in_elapsed = s_tdata[ELAPSED_W-1:0];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_beat    = s_tvalid && s_tready;
    assign start_beat = in_beat && (in_opcode == OP_START);
    assign div_busy   = (state_reg == ST_DIV);
    assign cfg_ready  = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_W-2){1'b0}}, out_flag_reg, out_sat_reg, out_count_reg};

    assign phase_sum = {1'b0, phase_reg} + (PHASE_W+1)'(in_elapsed);
    assign on_ext    = PHASE_W'(on_reg);
    assign off_ext   = PHASE_W'(off_reg);

    assign mul_step  = {acc_reg[PROD_W-2:0], 1'b0}
                     + (rsh_reg[RATE_W-1] ? PROD_W'(elapsed_reg) : '0);

    assign trial      = {rem_reg, dq_reg[QUOT_W-1]};
    assign trial_ge   = (trial >= {1'b0, on_reg});
    assign trial_diff = trial - {1'b0, on_reg};

    assign total     = {1'b0, dq_reg} + (QUOT_W+1)'(carry_reg);
    assign total_sat = |total[QUOT_W:FRAC_BITS+COUNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CONT;
            rate_reg <= '0;
            on_reg   <= '0;
            off_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_EMIT_MODE:  mode_reg <= cfg_data[MODE_W-1:0];
                REG_EVENT_RATE: rate_reg <= cfg_data[RATE_W-1:0];
                REG_ON_TIME:    on_reg   <= cfg_data[TIME_W-1:0];
                REG_OFF_TIME:   off_reg  <= cfg_data[TIME_W-1:0];
                default:        mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            carry_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            carry_reg     <= carry_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg   <= elapsed_next;
        rsh_reg       <= rsh_next;
        acc_reg       <= acc_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        spread_reg    <= spread_next;
        count_reg     <= count_next;
        sat_reg       <= sat_next;
        out_count_reg <= out_count_next;
        out_sat_reg   <= out_sat_next;
        out_flag_reg  <= out_flag_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        flag_next      = flag_reg;
        elapsed_next   = elapsed_reg;
        rsh_next       = rsh_reg;
        acc_next       = acc_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        spread_next    = spread_reg;
        count_next     = count_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_count_next = out_count_reg;
        out_sat_next   = out_sat_reg;
        out_flag_next  = out_flag_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                count_next = '0;
                sat_next   = 1'b0;
                if (in_beat)
                begin
                    state_next = ST_FINISH;
                    case (in_opcode)
                        OP_TICK:
                        begin
                            elapsed_next = in_elapsed;
                            phase_next   = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
                            state_next   = ST_DECIDE;
                        end
                        OP_START:
                        begin
                            phase_next = '0;
                            carry_next = '0;
                            flag_next  = 1'b1;
                        end
                        OP_STOP:
                        begin
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                            flag_next = flag_reg;
                        end
                    endcase
                end
            end

            ST_DECIDE:
            begin
                state_next  = ST_FINISH;
                rsh_next    = rate_reg;
                acc_next    = '0;
                cnt_next    = CNT_W'(RATE_W);
                spread_next = 1'b1;
                case (mode_reg)
                    MODE_CONT:
                    begin
                        if (flag_reg)
                        begin
                            phase_next  = '0;
                            spread_next = 1'b0;
                            state_next  = ST_MUL;
                        end
                    end
                    MODE_INTERVAL:
                    begin
                        if (flag_reg)
                        begin
                            if (phase_reg < on_ext)
                            begin
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                phase_next = phase_reg - on_ext;
                                flag_next  = 1'b0;
                            end
                        end
                        else if (phase_reg > off_ext)
                        begin
                            phase_next = phase_reg - off_ext;
                            flag_next  = 1'b1;
                        end
                    end
                    MODE_BURST:
                    begin
                        if (phase_reg < on_ext)
                        begin
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            flag_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_MUL:
            begin
                acc_next = mul_step;
                rsh_next = {rsh_reg[RATE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    rem_next = '0;
                    cnt_next = CNT_W'(QUOT_W);
                    if (spread_reg)
                    begin
                        dq_next    = {mul_step, {FRAC_BITS{1'b0}}};
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        dq_next    = QUOT_W'(mul_step);
                        state_next = ST_SETTLE;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
                dq_next  = {dq_reg[QUOT_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_SETTLE;
                end
            end

            ST_SETTLE:
            begin
                carry_next = total[FRAC_BITS-1:0];
                sat_next   = total_sat;
                count_next = total_sat ? '1 : total[FRAC_BITS+COUNT_W-1:FRAC_BITS];
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_sat_next   = sat_reg;
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_rem_below_divisor, div_busy |-> (rem_reg < on_reg), "remainder out of range")
    `ASSERT_CLK(a_div_nonzero, div_busy |-> (on_reg != '0), "divide by zero on_time")
    `ASSERT_CLK(a_start_clears, start_beat |=> (phase_reg == '0 && carry_reg == '0 && flag_reg), "start did not clear")
    `ASSERT_ALWAYS(a_busy_not_ready, (state_reg != ST_IDLE) |-> !s_tready, "input taken while busy")

endmodule

/* tb/sv/burst_rate_emission_checker.sv */
// Checker for the burst rate emission scheduler: tracks register writes, predicts
// one result beat per input beat and compares it with the output stream.
// Depends on brs_pkg for widths, opcodes, modes and register indexes.
`timescale 1ns / 1ps

module burst_rate_emission_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [brs_pkg::S_TDATA_W-1:0]     s_tdata,   // elapsed_time, zero pad
    input  logic [brs_pkg::OPCODE_W-1:0]      s_tuser,   // opcode
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [brs_pkg::M_TDATA_W-1:0]     m_tdata,   // emit_count, count_saturated,
                                                         // emitting_now, zero pad
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [brs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                errors,
    output int                                pending
);

    import brs_pkg::*;

    typedef struct packed {
        logic               emitting;
        logic               saturated;
        logic [COUNT_W-1:0] count;
    } emission_t;

    localparam logic [63:0] COUNT_LIMIT = 64'd65535;

    logic [MODE_W-1:0]   mode_r;
    logic [RATE_W-1:0]   rate_r;
    logic [TIME_W-1:0]   on_r;
    logic [TIME_W-1:0]   off_r;

    logic [PHASE_W-1:0]  phase_acc;
    logic [FRAC_BITS-1:0] carry_acc;
    logic                emitting;

    emission_t expected_emissions[$];
    emission_t want;
    emission_t got;

    function automatic emission_t settle_events(input logic [63:0] amount);
        emission_t   res;
        logic [63:0] total;
        logic [63:0] whole;
        total     = amount + {48'd0, carry_acc};
        whole     = total >> FRAC_BITS;
        carry_acc = total[FRAC_BITS-1:0];
        res.emitting = 1'b0;
        if (whole > COUNT_LIMIT)
        begin
            res.count     = '1;
            res.saturated = 1'b1;
        end
        else
        begin
            res.count     = whole[COUNT_W-1:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [63:0] spread_events(input logic [ELAPSED_W-1:0] et);
        logic [63:0] prod;
        prod = {48'd0, rate_r} * {44'd0, et};
        return (prod << FRAC_BITS) / {40'd0, on_r};
    endfunction

    function automatic emission_t predict_emission(input logic [OPCODE_W-1:0] op,
                                                   input logic [ELAPSED_W-1:0] et);
        emission_t   res;
        logic [32:0] sum;
        res = '0;
        if (op == OP_START)
        begin
            phase_acc = '0;
            carry_acc = '0;
            emitting  = 1'b1;
        end
        else if (op == OP_STOP)
        begin
            emitting = 1'b0;
        end
        else if (op == OP_TICK)
        begin
            sum       = {1'b0, phase_acc} + {13'd0, et};
            phase_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            case (mode_r)
                MODE_CONT:
                begin
                    if (emitting)
                    begin
                        res       = settle_events({48'd0, rate_r} * {44'd0, et});
                        phase_acc = '0;
                    end
                end
                MODE_INTERVAL:
                begin
                    if (emitting)
                    begin
                        if (phase_acc < {8'd0, on_r})
                            res = settle_events(spread_events(et));
                        else
                        begin
                            phase_acc = phase_acc - {8'd0, on_r};
                            emitting  = 1'b0;
                        end
                    end
                    else if (phase_acc > {8'd0, off_r})
                    begin
                        phase_acc = phase_acc - {8'd0, off_r};
                        emitting  = 1'b1;
                    end
                end
                MODE_BURST:
                begin
                    if (phase_acc < {8'd0, on_r})
                        res = settle_events(spread_events(et));
                    else
                        emitting = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        res.emitting = emitting;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mode_r    = '0;
            rate_r    = '0;
            on_r      = '0;
            off_r     = '0;
            phase_acc = '0;
            carry_acc = '0;
            emitting  = 1'b0;
            expected_emissions.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[COUNT_W+1:0];
                if (expected_emissions.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_emissions.pop_front();
                    if (got.count !== want.count)
                    begin
                        $display("%0t: emit_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        errors++;
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        $display("%0t: count_saturated expected %0b actual %0b",
                                 $time, want.saturated, got.saturated);
                        errors++;
                    end
                    if (got.emitting !== want.emitting)
                    begin
                        $display("%0t: emitting_now expected %0b actual %0b",
                                 $time, want.emitting, got.emitting);
                        errors++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    REG_EMIT_MODE:  mode_r = cfg_data[MODE_W-1:0];
                    REG_EVENT_RATE: rate_r = cfg_data[RATE_W-1:0];
                    REG_ON_TIME:    on_r   = cfg_data[TIME_W-1:0];
                    REG_OFF_TIME:   off_r  = cfg_data[TIME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (s_tvalid && s_tready)
                expected_emissions.insert(expected_emissions.size(),
                    predict_emission(s_tuser, s_tdata[ELAPSED_W-1:0]));

            pending = expected_emissions.size();
        end
    end

endmodule

/* tb/sv/burst_rate_emission_scheduler_tb.sv */
// Top of the scheduler testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on brs_pkg, the scheduler RTL and burst_rate_emission_checker.
`timescale 1ns / 1ps

module burst_rate_emission_scheduler_tb;

    import brs_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0]   TIME_MAX    = 24'hFFFFFF;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;
    localparam int SEGMENTS   = 12;
    localparam int SEG_ITEMS  = 160;
    localparam int IDLE_LIMIT = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [OPCODE_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int errors;
    int pending;
    int src_idle;
    int sink_idle;
    int beats_sent;
    int reg_writes;
    int stall_cycles;

    logic [MODE_W-1:0]    seg_mode;
    logic [RATE_W-1:0]    seg_rate;
    logic [TIME_W-1:0]    seg_on;
    logic [31:0]          et_scale;
    logic [OPCODE_W-1:0]  op;
    logic [ELAPSED_W-1:0] et;
    int                   seg;
    int                   n;
    int                   pick;

    burst_rate_emission_scheduler DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    burst_rate_emission_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         stall_cycles, pending);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_beat(input logic [OPCODE_W-1:0] code,
                             input logic [ELAPSED_W-1:0] dt);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {{(S_TDATA_W-ELAPSED_W){1'b0}}, dt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        @(negedge clk);
    endtask

    // drain all results, then load a full register set
    task automatic configure(input logic [MODE_W-1:0] mode, input logic [RATE_W-1:0] rate,
                             input logic [TIME_W-1:0] on_t, input logic [TIME_W-1:0] off_t);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(REG_EMIT_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, mode});
        write_reg(REG_EVENT_RATE, {{(CFG_DATA_W-RATE_W){1'b0}}, rate});
        write_reg(REG_ON_TIME, on_t);
        write_reg(REG_OFF_TIME, off_t);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 24'd1;
            2:       return TIME_MAX;
            3, 4:    return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(262144, 1024));
        endcase
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_addr     = '0;
        cfg_data     = '0;
        src_idle     = 8;
        sink_idle    = 69;
        beats_sent   = 0;
        reg_writes   = 0;
        stall_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_beat(OP_TICK, '0);
        send_beat(OP_START, ELAPSED_MAX);
        send_beat(OP_TICK, ELAPSED_MAX);
        send_beat(OP_UNUSED, ELAPSED_MAX);

        configure(MODE_CONT, 16'hFFFF, '0, '0);
        send_beat(OP_TICK, ELAPSED_MAX);
        send_beat(OP_TICK, 20'd1);
        send_beat(OP_STOP, '0);
        send_beat(OP_TICK, 20'd1000);

        configure(MODE_INTERVAL, 16'hFFFF, 24'd1, '0);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, '0);
        send_beat(OP_TICK, 20'd1);
        send_beat(OP_TICK, 20'd1);

        // cross the on phase and then the idle phase
        configure(MODE_INTERVAL, 16'd1000, 24'd65536, 24'd32768);
        send_beat(OP_START, '0);
        repeat (4) send_beat(OP_TICK, 20'd30000);

        configure(MODE_BURST, 16'hFFFF, TIME_MAX, TIME_MAX);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, ELAPSED_MAX);
        send_beat(OP_TICK, ELAPSED_MAX);

        configure(MODE_UNUSED, 16'd1, 24'd1, 24'd1);
        send_beat(OP_TICK, 20'd500);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, 20'd500);

        configure(MODE_BURST, 16'd10, '0, '0);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, 20'd100);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS / 3)
            begin
                src_idle  = 69;
                sink_idle = 8;
            end
            else if (seg == 2 * SEGMENTS / 3)
            begin
                src_idle  = 0;
                sink_idle = 0;
            end

            pick = $urandom_range(9);
            seg_mode = (pick < 3) ? MODE_CONT : (pick < 6) ? MODE_INTERVAL :
                       (pick < 9) ? MODE_BURST : MODE_UNUSED;
            case ($urandom_range(5))
                0:       seg_rate = '0;
                1:       seg_rate = 16'hFFFF;
                2, 3:    seg_rate = RATE_W'($urandom_range(100, 1));
                default: seg_rate = RATE_W'($urandom);
            endcase
            seg_on = pick_time();
            configure(seg_mode, seg_rate, seg_on, pick_time());

            et_scale = (seg_mode == MODE_CONT) ? 32'd4096 : {8'd0, seg_on} >> 3;
            if (et_scale == 0)
                et_scale = 64;
            if (et_scale > ELAPSED_MAX)
                et_scale = 32'(ELAPSED_MAX);

            send_beat(OP_START, ELAPSED_W'($urandom));
            for (n = 0; n < SEG_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                op = (pick < 4) ? OP_START : (pick < 7) ? OP_STOP :
                     (pick < 9) ? OP_UNUSED : OP_TICK;
                pick = $urandom_range(99);
                if (pick < 60)
                    et = ELAPSED_W'($urandom_range(et_scale, 0));
                else if (pick < 80)
                    et = ELAPSED_W'($urandom_range(4095, 0));
                else
                    et = ELAPSED_W'($urandom);
                send_beat(op, et);
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        $display("Covered %0d input beats and %0d register writes across continuous,",
                 beats_sent, reg_writes);
        $display("interval, single burst and unused modes under three stall profiles.");
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
